// ===== sv/rba_pkg.sv =====
package rba_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int BLK_W      = $clog2(MAX_BLOCKS);
	localparam int NUM_W      = $clog2(MAX_BLOCKS + 1);
	localparam int COUNT_BITS = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_REF     = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_EMPTY         = 3'd1;
	localparam logic [2:0] ST_BAD_BLOCK     = 3'd2;
	localparam logic [2:0] ST_ZERO          = 3'd3;
	localparam logic [2:0] ST_SATURATED     = 3'd4;
	localparam logic [2:0] ST_NOT_ALLOCATED = 3'd5;

	typedef struct packed {
		logic [1:0]       operation;
		logic [BLK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [BLK_W-1:0]      granted_block;
		logic [COUNT_BITS-1:0] count_after;
		logic [NUM_W-1:0]      free_blocks;
		logic [NUM_W-1:0]      blocks_in_use;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [BLK_W-1:0] blk;
		logic             in_range;
	} cmd_t;

endpackage

// ===== sv/refcounted_block_allocator.sv =====
// Channel    Direction  Handshake             Payload
// request    in         push / full           req (operation, block_number)
// response   out        pop / empty           rsp (status, block, count, free, in use)
// config     in         cfg_we, no wait       cfg_wdata (block_count)
//
// In the execution stage a request first does the registered read of the count and
// stack memories in S_READ, then the update and the write back in S_EXEC.
// A two-entry request queue accepts up to two requests while a response waits in its register.
// After reset and after every block_count write, every entry of the count memory is
// cleared in turn, during which full stays high.
module refcounted_block_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  rba_pkg::req_t             req,
	output logic                      empty,
	input  logic                      pop,
	output rba_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [rba_pkg::NUM_W-1:0] cfg_wdata
);

	logic                      clearing;
	logic [rba_pkg::NUM_W-1:0] n_eff;
	logic                      q_valid;
	logic                      q_deq;
	rba_pkg::cmd_t             q_head;
	logic                      res_valid;
	rba_pkg::rsp_t             res;

	rba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.hold      (clearing),
		.n_eff     (n_eff),
		.full      (full),
		.deq       (q_deq),
		.head_valid(q_valid),
		.head      (q_head)
	);

	rba_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.n_eff    (n_eff),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_deq    (q_deq),
		.res_valid(res_valid),
		.res      (res),
		.pop      (pop)
	);

	assign empty = ~res_valid;
	assign rsp   = res;

endmodule

// ===== sv/rba_ram.sv =====
module rba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/rba_front.sv =====
module rba_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rba_pkg::req_t             req,
	input  logic                      hold,
	input  logic [rba_pkg::NUM_W-1:0] n_eff,
	output logic                      full,
	input  logic                      deq,
	output logic                      head_valid,
	output rba_pkg::cmd_t             head
);

	rba_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          accept;
	logic          take;
	rba_pkg::cmd_t cmd;

	// Requests are classified on entry so the back end sees a range flag.
	always_comb begin
		cmd.op       = req.operation;
		cmd.blk      = req.block_number;
		cmd.in_range = {1'b0, req.block_number} < n_eff;
	end

	assign full       = (fill_q == 2'd2) | hold;
	assign accept     = push & ~full;
	assign head_valid = fill_q != 2'd0;
	assign take       = deq & head_valid;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, accept} - {1'b0, take};
		end
	end

endmodule

// ===== sv/rba_back.sv =====
module rba_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rba_pkg::NUM_W-1:0] cfg_wdata,
	output logic [rba_pkg::NUM_W-1:0] n_eff,
	output logic                      clearing,
	input  logic                      q_valid,
	input  rba_pkg::cmd_t             q_head,
	output logic                      q_deq,
	output logic                      res_valid,
	output rba_pkg::rsp_t             res,
	input  logic                      pop
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_READ,
		S_EXEC
	} state_t;

	state_t                             state_q;
	logic [rba_pkg::NUM_W-1:0]          block_count_q;
	logic [rba_pkg::NUM_W-1:0]          depth_q;
	logic [rba_pkg::NUM_W-1:0]          mark_q;
	logic [rba_pkg::NUM_W-1:0]          in_use_q;
	logic [rba_pkg::BLK_W-1:0]          clr_q;
	rba_pkg::cmd_t                      cmd_q;
	rba_pkg::rsp_t                      res_q;
	logic                               res_valid_q;

	logic [rba_pkg::NUM_W-1:0]          cfg_n;
	logic                               slot_free;

	logic                               stk_we;
	logic [rba_pkg::BLK_W-1:0]          stk_waddr;
	logic [rba_pkg::BLK_W-1:0]          stk_wdata;
	logic [rba_pkg::BLK_W-1:0]          stk_raddr;
	logic [rba_pkg::BLK_W-1:0]          stk_rdata;
	logic                               cnt_we;
	logic [rba_pkg::BLK_W-1:0]          cnt_waddr;
	logic [rba_pkg::COUNT_BITS-1:0]     cnt_wdata;
	logic [rba_pkg::BLK_W-1:0]          cnt_raddr;
	logic [rba_pkg::COUNT_BITS-1:0]     cnt_rdata;

	logic                               ex_stk_we;
	logic [rba_pkg::BLK_W-1:0]          ex_stk_waddr;
	logic [rba_pkg::BLK_W-1:0]          ex_stk_wdata;
	logic                               ex_cnt_we;
	logic [rba_pkg::BLK_W-1:0]          ex_cnt_waddr;
	logic [rba_pkg::COUNT_BITS-1:0]     ex_cnt_wdata;
	logic [rba_pkg::NUM_W-1:0]          depth_n;
	logic [rba_pkg::NUM_W-1:0]          mark_n;
	logic [rba_pkg::NUM_W-1:0]          in_use_n;
	rba_pkg::rsp_t                      rsp_n;

	assign n_eff = (block_count_q > rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS))
		? rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS) : block_count_q;
	assign cfg_n = (cfg_wdata > rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS))
		? rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS) : cfg_wdata;

	assign clearing  = state_q == S_CLEAR;
	assign slot_free = ~res_valid_q | pop;
	assign q_deq     = (state_q == S_READ) & q_valid & slot_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign stk_raddr = rba_pkg::BLK_W'(depth_q - rba_pkg::NUM_W'(1));
	assign cnt_raddr = q_head.blk;

	// Stack entries below the lowest depth reached since initialization were
	// never written, so their value is computed from n_eff and the depth, not read.
	always_comb begin
		logic [rba_pkg::BLK_W-1:0]      top_entry;
		logic [rba_pkg::COUNT_BITS-1:0] cnt;
		logic [rba_pkg::NUM_W-1:0]      dm1;

		dm1       = depth_q - rba_pkg::NUM_W'(1);
		top_entry = (mark_q < depth_q) ? stk_rdata
			: rba_pkg::BLK_W'(n_eff - depth_q);
		cnt       = cnt_rdata;

		ex_stk_we    = 1'b0;
		ex_stk_waddr = rba_pkg::BLK_W'(depth_q);
		ex_stk_wdata = cmd_q.blk;
		ex_cnt_we    = 1'b0;
		ex_cnt_waddr = cmd_q.blk;
		ex_cnt_wdata = cnt;
		depth_n      = depth_q;
		mark_n       = mark_q;
		in_use_n     = in_use_q;

		rsp_n.status        = rba_pkg::ST_OK;
		rsp_n.granted_block = cmd_q.blk;
		rsp_n.count_after   = '0;

		if (cmd_q.op == rba_pkg::OP_ALLOC) begin
			if (depth_q == '0) begin
				rsp_n.status        = rba_pkg::ST_EMPTY;
				rsp_n.granted_block = '0;
			end else begin
				depth_n             = dm1;
				if (dm1 < mark_q) begin
					mark_n = dm1;
				end
				rsp_n.granted_block = top_entry;
				rsp_n.count_after   = rba_pkg::COUNT_BITS'(1);
				ex_cnt_we           = 1'b1;
				ex_cnt_waddr        = top_entry;
				ex_cnt_wdata        = rba_pkg::COUNT_BITS'(1);
				in_use_n            = in_use_q + rba_pkg::NUM_W'(1);
			end
		end else if (!cmd_q.in_range) begin
			rsp_n.status = (cmd_q.op == rba_pkg::OP_NOP) ? rba_pkg::ST_OK
				: rba_pkg::ST_BAD_BLOCK;
		end else begin
			rsp_n.count_after = cnt;
			unique case (cmd_q.op)
				rba_pkg::OP_RELEASE: begin
					if (cnt == '0) begin
						rsp_n.status = rba_pkg::ST_ZERO;
					end else begin
						ex_cnt_we         = 1'b1;
						ex_cnt_wdata      = cnt - rba_pkg::COUNT_BITS'(1);
						rsp_n.count_after = ex_cnt_wdata;
						if (ex_cnt_wdata == '0) begin
							if (in_use_q != '0) begin
								in_use_n = in_use_q - rba_pkg::NUM_W'(1);
							end
							if (depth_q < rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS)) begin
								ex_stk_we = 1'b1;
								depth_n   = depth_q + rba_pkg::NUM_W'(1);
							end
						end
					end
				end
				rba_pkg::OP_REF: begin
					if (cnt == '0) begin
						rsp_n.status = rba_pkg::ST_NOT_ALLOCATED;
					end else if (cnt == rba_pkg::COUNT_MAX) begin
						rsp_n.status = rba_pkg::ST_SATURATED;
					end else begin
						ex_cnt_we         = 1'b1;
						ex_cnt_wdata      = cnt + rba_pkg::COUNT_BITS'(1);
						rsp_n.count_after = ex_cnt_wdata;
					end
				end
				rba_pkg::OP_ALLOC, rba_pkg::OP_NOP: begin
				end
			endcase
		end

		rsp_n.free_blocks   = depth_n;
		rsp_n.blocks_in_use = in_use_n;
	end

	always_comb begin
		stk_we    = (state_q == S_EXEC) & ex_stk_we;
		stk_waddr = ex_stk_waddr;
		stk_wdata = ex_stk_wdata;
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = (state_q == S_EXEC) & ex_cnt_we;
			cnt_waddr = ex_cnt_waddr;
			cnt_wdata = ex_cnt_wdata;
		end
	end

	rba_ram #(
		.WIDTH(rba_pkg::BLK_W),
		.DEPTH(rba_pkg::MAX_BLOCKS)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	rba_ram #(
		.WIDTH(rba_pkg::COUNT_BITS),
		.DEPTH(rba_pkg::MAX_BLOCKS)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_deq) begin
			cmd_q <= q_head;
		end
		if (state_q == S_EXEC) begin
			res_q <= rsp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			block_count_q <= rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS);
			depth_q       <= rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS);
			mark_q        <= rba_pkg::NUM_W'(rba_pkg::MAX_BLOCKS);
			in_use_q      <= '0;
			clr_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_EXEC) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				state_q       <= S_CLEAR;
				block_count_q <= cfg_wdata;
				depth_q       <= cfg_n;
				mark_q        <= cfg_n;
				in_use_q      <= '0;
				clr_q         <= '0;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + rba_pkg::BLK_W'(1);
						if (clr_q == rba_pkg::BLK_W'(rba_pkg::MAX_BLOCKS - 1)) begin
							state_q <= S_READ;
						end
					end
					S_READ: begin
						if (q_deq) begin
							state_q <= S_EXEC;
						end
					end
					S_EXEC: begin
						depth_q  <= depth_n;
						mark_q   <= mark_n;
						in_use_q <= in_use_n;
						state_q  <= S_READ;
					end
					default: begin
						state_q <= S_CLEAR;
					end
				endcase
			end
		end
	end

endmodule

// ===== test/rba_monitor.sv =====
`timescale 1ns / 100ps

module rba_monitor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      full,
	input  rba_pkg::req_t             req,
	input  logic                      pop,
	input  logic                      empty,
	input  rba_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [rba_pkg::NUM_W-1:0] cfg_wdata,
	output int                        mismatches,
	output int                        owed_count
);
	import rba_pkg::*;

	logic [BLK_W-1:0]      free_list [MAX_BLOCKS];
	logic [COUNT_BITS-1:0] refs      [MAX_BLOCKS];
	int                    free_top;
	int                    live_blocks;
	logic [NUM_W-1:0]      block_count;
	rsp_t                  owed_rsp [$];
	int                    rsp_index;

	function automatic int usable_blocks();
		return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
	endfunction

	function automatic void refill();
		int n;
		n = usable_blocks();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			refs[i] = '0;
			free_list[i] = (i < n) ? BLK_W'(n - 1 - i) : '0;
		end
		free_top = n;
		live_blocks = 0;
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		logic [COUNT_BITS-1:0] c;
		o.status = ST_OK;
		o.granted_block = r.block_number;
		o.count_after = '0;
		if (r.operation == OP_ALLOC) begin
			if (free_top == 0) begin
				o.status = ST_EMPTY;
				o.granted_block = '0;
			end else begin
				free_top--;
				o.granted_block = free_list[free_top];
				refs[o.granted_block] = COUNT_BITS'(1);
				live_blocks++;
				o.count_after = COUNT_BITS'(1);
			end
		end else if (r.block_number >= usable_blocks()) begin
			if (r.operation != OP_NOP) o.status = ST_BAD_BLOCK;
		end else begin
			c = refs[r.block_number];
			case (r.operation)
				OP_RELEASE: begin
					if (c == '0) begin
						o.status = ST_ZERO;
					end else begin
						c = c - 1'b1;
						refs[r.block_number] = c;
						if (c == '0) begin
							if (live_blocks > 0) live_blocks--;
							if (free_top < MAX_BLOCKS) begin
								free_list[free_top] = r.block_number;
								free_top++;
							end
						end
					end
				end
				OP_REF: begin
					if (c == '0) begin
						o.status = ST_NOT_ALLOCATED;
					end else if (c == COUNT_MAX) begin
						o.status = ST_SATURATED;
					end else begin
						c = c + 1'b1;
						refs[r.block_number] = c;
					end
				end
				default: ;
			endcase
			o.count_after = c;
		end
		o.free_blocks = NUM_W'(free_top);
		o.blocks_in_use = NUM_W'(live_blocks);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			block_count = NUM_W'(MAX_BLOCKS);
			refill();
			owed_rsp.delete();
			mismatches = 0;
			rsp_index = 0;
		end else begin
			if (cfg_we) begin
				block_count = cfg_wdata;
				refill();
			end
			if (push && !full) owed_rsp.insert(owed_rsp.size(), apply_request(req));
			if (pop && !empty) begin
				if (owed_rsp.size() == 0) begin
					if (mismatches < 10)
						$display("transfer %0d: response with no request outstanding: %p",
							rsp_index, rsp);
					mismatches++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.status !== want.status || rsp.granted_block !== want.granted_block
						|| rsp.count_after !== want.count_after
						|| rsp.free_blocks !== want.free_blocks
						|| rsp.blocks_in_use !== want.blocks_in_use) begin
						if (mismatches < 10) begin
							$display("transfer %0d: expected st %0d blk %0d cnt %0d free %0d used %0d",
								rsp_index, want.status, want.granted_block, want.count_after,
								want.free_blocks, want.blocks_in_use);
							$display("transfer %0d: actual   st %0d blk %0d cnt %0d free %0d used %0d",
								rsp_index, rsp.status, rsp.granted_block, rsp.count_after,
								rsp.free_blocks, rsp.blocks_in_use);
						end
						mismatches++;
					end
				end
				rsp_index++;
			end
		end
		owed_count = owed_rsp.size();
	end

endmodule

// ===== test/tb_refcounted_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_refcounted_block_allocator;
	import rba_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	req_t             req = '0;
	logic             empty;
	logic             pop = 1'b0;
	rsp_t             rsp;
	logic             cfg_we = 1'b0;
	logic [NUM_W-1:0] cfg_wdata = '0;
	int               mismatches;
	int               owed_count;
	int               sent = 0;
	int               received = 0;
	int               span = MAX_BLOCKS;
	bit               calm = 1'b0;

	refcounted_block_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	rba_monitor u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.pop(pop),
		.empty(empty),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.owed_count(owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (pop && !empty) received <= received + 1;
	end

	// The response side stalls once for a long stretch so that the request side fills up.
	initial begin : receiver
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && received >= 300) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		wait (arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) stall = 0;
			else stall++;
		end
		$display("refcounted_block_allocator test failed");
		$finish;
	end

	task automatic send_item(input logic [1:0] op, input int blk);
		req_t r;
		r.operation = op;
		r.block_number = BLK_W'(blk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	task automatic send_run(input logic [1:0] op, input int blk, input int n_items);
		repeat (n_items) send_item(op, blk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (received != sent) @(posedge clk);
	endtask

	task automatic configure(input int value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= NUM_W'(value);
		span = (value > MAX_BLOCKS) ? MAX_BLOCKS : value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int n_items);
		int pick;
		int near;
		int wide;
		logic [1:0] op;
		int blk;
		wide = (span > 0) ? span - 1 : 0;
		near = (wide > 15) ? 15 : wide;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 36) op = OP_ALLOC;
			else if (pick < 66) op = OP_RELEASE;
			else if (pick < 96) op = OP_REF;
			else op = OP_NOP;
			pick = $urandom_range(0, 99);
			if (pick < 75) blk = $urandom_range(0, near);
			else if (pick < 90) blk = $urandom_range(0, wide);
			else blk = $urandom_range(0, MAX_BLOCKS - 1);
			send_item(op, blk);
		end
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_ALLOC, 0);
		send_item(OP_ALLOC, 1023);
		send_item(OP_REF, 0);
		send_item(OP_RELEASE, 1);
		send_item(OP_RELEASE, 1);
		send_item(OP_REF, 1);
		send_item(OP_ALLOC, 0);
		send_item(OP_NOP, 1023);
		send_item(OP_NOP, 0);

		configure(2);
		send_item(OP_ALLOC, 0);
		send_item(OP_ALLOC, 0);
		send_item(OP_ALLOC, 0);
		send_item(OP_RELEASE, 2);
		send_item(OP_REF, 1023);
		send_item(OP_NOP, 700);
		send_item(OP_RELEASE, 0);
		send_item(OP_ALLOC, 0);

		configure(0);
		send_item(OP_ALLOC, 0);
		send_item(OP_RELEASE, 0);
		send_item(OP_REF, 0);
		send_item(OP_NOP, 3);

		configure(1024);
		run_phase(300);

		// Drive one block up to the counter maximum and back down to zero, then release it once more.
		configure(4);
		send_item(OP_ALLOC, 0);
		send_run(OP_REF, 0, 256);
		send_run(OP_RELEASE, 0, 256);
		run_phase(60);

		configure(1);
		run_phase(120);
		configure(3);
		run_phase(150);
		configure(17);
		run_phase(250);
		configure(2047);
		run_phase(250);
		configure(600);
		run_phase(250);

		configure(1024);
		calm = 1'b1;
		run_phase(250);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && owed_count == 0)
			$display("refcounted_block_allocator test passed");
		else
			$display("refcounted_block_allocator test failed");
		$finish;
	end

endmodule

// ===== refcounted_block_allocator.f =====
sv/rba_pkg.sv
sv/rba_ram.sv
sv/rba_front.sv
sv/rba_back.sv
sv/refcounted_block_allocator.sv
test/rba_monitor.sv
test/tb_refcounted_block_allocator.sv
